FILE: rtl/core/irb_pkg.sv
// Shared types, constants and helper functions for the IR beacon transmitter.
// Used by every module of the block and by its checker; depends on nothing.
package irb_pkg;

   localparam int IdWidth = 32;
   localparam int BitIdxW = $clog2(IdWidth);

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxW-1:0] CsrBeaconId    = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrIdBits      = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrCarrierTop  = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrUnitTicks   = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrPeriodUnits = 3'd4;

   // Register values after reset.
   localparam logic [31:0] BeaconIdReset    = 32'd0;
   localparam logic [5:0]  IdBitsReset      = 6'd32;
   localparam logic [15:0] CarrierTopReset  = 16'd104;
   localparam logic [15:0] UnitTicksReset   = 16'd768;
   localparam logic [7:0]  PeriodUnitsReset = 8'd10;

   // Frame phase codes as shown on the result channel.
   localparam logic [1:0] FrmStartMark  = 2'd0;
   localparam logic [1:0] FrmStartSpace = 2'd1;
   localparam logic [1:0] FrmData       = 2'd2;
   localparam logic [1:0] FrmEndSpace   = 2'd3;

   typedef struct packed {
      logic [31:0] beacon_id;
      logic [5:0]  id_bits;
      logic [15:0] carrier_top;
      logic [15:0] unit_ticks;
      logic [7:0]  period_units;
   } cfg_type;

   typedef enum logic [3:0] {
      PhStartMark  = 4'b0001,
      PhStartSpace = 4'b0010,
      PhData       = 4'b0100,
      PhEndSpace   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       led_level;
      logic       mark_active;
      logic [1:0] frame_phase;
      logic [4:0] current_bit;
      logic       frame_done;
   } result_type;

   // Index of the first (most significant) identifier bit sent. A zero bit
   // count acts as one bit, and a count above the identifier width is clamped.
   function automatic logic [BitIdxW-1:0] last_bit_index(input logic [5:0] id_bits);
      logic [BitIdxW-1:0] idx;
      if (id_bits == 6'd0) begin
         idx = '0;
      end else if (id_bits > 6'(IdWidth)) begin
         idx = BitIdxW'(IdWidth - 1);
      end else begin
         idx = BitIdxW'(id_bits - 6'd1);
      end
      return idx;
   endfunction

   localparam logic [BitIdxW-1:0] BitIndexReset = last_bit_index(IdBitsReset);

   function automatic logic [1:0] phase_code(input phase_type phase);
      logic [1:0] code;
      unique case (phase)
         PhStartMark:  code = FrmStartMark;
         PhStartSpace: code = FrmStartSpace;
         PhData:       code = FrmData;
         PhEndSpace:   code = FrmEndSpace;
         default:      code = FrmStartMark;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/core/irb_if.sv
// Valid/ready channel interfaces for the IR beacon transmitter.
// The request channel carries one tick flag; the response channel one result.
interface irb_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

interface irb_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_level;
   logic       mark_active;
   logic [1:0] frame_phase;
   logic [4:0] current_bit;
   logic       frame_done;

   modport source (output valid, output led_level, output mark_active,
                   output frame_phase, output current_bit, output frame_done,
                   input ready);
   modport sink   (input valid, input led_level, input mark_active,
                   input frame_phase, input current_bit, input frame_done,
                   output ready);
endinterface

FILE: rtl/core/irb_csr.sv
// Configuration registers of the IR beacon transmitter.
// Depends on irb_pkg for register indexes, reset values and the cfg_type struct.
module irb_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [irb_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [irb_pkg::CsrDataW-1:0] csr_wdata,
   output irb_pkg::cfg_type             cfg
);

   irb_pkg::cfg_type cfg_ff;
   irb_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            irb_pkg::CsrBeaconId:    cfg_in.beacon_id    = csr_wdata;
            irb_pkg::CsrIdBits:      cfg_in.id_bits      = csr_wdata[5:0];
            irb_pkg::CsrCarrierTop:  cfg_in.carrier_top  = csr_wdata[15:0];
            irb_pkg::CsrUnitTicks:   cfg_in.unit_ticks   = csr_wdata[15:0];
            irb_pkg::CsrPeriodUnits: cfg_in.period_units = csr_wdata[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beacon_id    <= irb_pkg::BeaconIdReset;
         cfg_ff.id_bits      <= irb_pkg::IdBitsReset;
         cfg_ff.carrier_top  <= irb_pkg::CarrierTopReset;
         cfg_ff.unit_ticks   <= irb_pkg::UnitTicksReset;
         cfg_ff.period_units <= irb_pkg::PeriodUnitsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/irb_sequencer.sv
// Frame timing for the IR beacon: tick, unit and carrier counters, frame phase,
// Manchester bit position and carrier latch. Depends on irb_pkg.
module irb_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  irb_pkg::cfg_type       cfg,
   input  logic                   step,
   input  logic                   tick,
   output irb_pkg::result_type    result
);

   logic [15:0]                 tick_count_ff, tick_count_in;
   logic [9:0]                  unit_count_ff, unit_count_in;
   irb_pkg::phase_type          phase_ff, phase_in;
   logic [irb_pkg::BitIdxW-1:0] bit_index_ff, bit_index_in;
   logic                        half_ff, half_in;
   logic [15:0]                 carr_count_ff, carr_count_in;
   logic                        carr_latch_ff, carr_latch_in;

   logic [9:0]  seg_units;
   logic [16:0] tick_plus;
   logic [10:0] unit_plus;
   logic        mark_now;
   logic        mark_next;
   logic        done;

   // Carrier is gated on during the start mark and during the mark half of
   // each data bit (a one marks first, a zero marks second).
   function automatic logic mark_of(input irb_pkg::phase_type phase,
                                    input logic [31:0] beacon_id,
                                    input logic [irb_pkg::BitIdxW-1:0] bit_index,
                                    input logic half);
      logic m;
      unique case (phase)
         irb_pkg::PhStartMark: m = 1'b1;
         irb_pkg::PhData:      m = beacon_id[bit_index] ^ half;
         default:              m = 1'b0;
      endcase
      return m;
   endfunction

   always_comb begin
      unique case (phase_ff)
         irb_pkg::PhStartMark:  seg_units = 10'({cfg.period_units, 1'b0})
                                           + 10'(cfg.period_units);
         irb_pkg::PhStartSpace: seg_units = 10'(cfg.period_units);
         irb_pkg::PhData:       seg_units = 10'(cfg.period_units >> 1);
         irb_pkg::PhEndSpace:   seg_units = 10'({cfg.period_units, 2'b00});
         default:               seg_units = 10'(cfg.period_units);
      endcase
   end

   assign tick_plus = {1'b0, tick_count_ff} + 17'd1;
   assign unit_plus = {1'b0, unit_count_ff} + 11'd1;
   assign mark_now  = mark_of(phase_ff, cfg.beacon_id, bit_index_ff, half_ff);

   always_comb begin
      tick_count_in = tick_count_ff;
      unit_count_in = unit_count_ff;
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      half_in       = half_ff;
      carr_count_in = carr_count_ff;
      carr_latch_in = carr_latch_ff;
      done          = 1'b0;

      if (step && tick) begin
         // The carrier counter always runs; the latch only toggles in a mark.
         if (carr_count_ff >= cfg.carrier_top) begin
            carr_count_in = '0;
            if (mark_now) begin
               carr_latch_in = ~carr_latch_ff;
            end
         end else begin
            carr_count_in = carr_count_ff + 16'd1;
         end

         if (tick_plus >= {1'b0, cfg.unit_ticks}) begin
            tick_count_in = '0;
            if (unit_plus >= {1'b0, seg_units}) begin
               unit_count_in = '0;
               unique case (phase_ff)
                  irb_pkg::PhStartMark: begin
                     phase_in = irb_pkg::PhStartSpace;
                  end
                  irb_pkg::PhStartSpace: begin
                     phase_in     = irb_pkg::PhData;
                     bit_index_in = irb_pkg::last_bit_index(cfg.id_bits);
                     half_in      = 1'b0;
                  end
                  irb_pkg::PhData: begin
                     if (!half_ff) begin
                        half_in = 1'b1;
                     end else begin
                        half_in = 1'b0;
                        if (bit_index_ff == '0) begin
                           phase_in = irb_pkg::PhEndSpace;
                        end else begin
                           bit_index_in = bit_index_ff - (irb_pkg::BitIdxW)'(1);
                        end
                     end
                  end
                  irb_pkg::PhEndSpace: begin
                     phase_in = irb_pkg::PhStartMark;
                     done     = 1'b1;
                  end
                  default: begin
                     phase_in = irb_pkg::PhStartMark;
                  end
               endcase
            end else begin
               unit_count_in = unit_plus[9:0];
            end
         end else begin
            tick_count_in = tick_plus[15:0];
         end
      end
   end

   // The result shows the state after this item's update.
   assign mark_next = mark_of(phase_in, cfg.beacon_id, bit_index_in, half_in);

   always_comb begin
      result.led_level   = mark_next & carr_latch_in;
      result.mark_active = mark_next;
      result.frame_phase = irb_pkg::phase_code(phase_in);
      result.current_bit = (phase_in == irb_pkg::PhData) ? 5'(bit_index_in) : 5'd0;
      result.frame_done  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         unit_count_ff <= '0;
         phase_ff      <= irb_pkg::PhStartMark;
         bit_index_ff  <= irb_pkg::BitIndexReset;
         half_ff       <= 1'b0;
         carr_count_ff <= '0;
         carr_latch_ff <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         unit_count_ff <= unit_count_in;
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         half_ff       <= half_in;
         carr_count_ff <= carr_count_in;
         carr_latch_ff <= carr_latch_in;
      end
   end

endmodule

FILE: rtl/core/irb_out_buf.sv
// Result register with a skid stage for the IR beacon transmitter.
// Depends on irb_pkg for result_type and on irb_rsp_if for the output channel.
module irb_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  irb_pkg::result_type push_data,
   output logic                in_ready,
   irb_rsp_if.source           rsp
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   irb_pkg::result_type main_ff, main_in;
   irb_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop      = main_valid_ff && rsp.ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         // Output register is free: the oldest waiting result moves in.
         skid_valid_in = 1'b0;
         main_valid_in = skid_valid_ff || push;
         main_in       = skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid       = main_valid_ff;
   assign rsp.led_level   = main_ff.led_level;
   assign rsp.mark_active = main_ff.mark_active;
   assign rsp.frame_phase = main_ff.frame_phase;
   assign rsp.current_bit = main_ff.current_bit;
   assign rsp.frame_done  = main_ff.frame_done;

endmodule

FILE: rtl/core/ir_beacon_manchester_transmitter.sv
// Top level of the IR beacon transmitter: configuration registers, frame
// sequencer and result buffer. Depends on irb_pkg and the irb_if interfaces.
//
// Every transfer on the request channel is one clock tick of the timebase
// (tick high) or a hold (tick low), and each produces exactly one transfer on
// the response channel carrying the pin level, the carrier gate, the frame
// phase, the data bit index and the end-of-frame flag, all as they stand after
// that tick. The block sends a repeating frame: three periods of gated carrier,
// one period of space, the identifier bits most significant first in
// Manchester code (a one is mark then space, a zero is space then mark, each
// half lasting half a period rounded down), then four periods of space. The
// block takes one request per clock cycle while the result buffer has room
// and registers each result. The counter update is a single combinational pass
// between the state registers and the result register, and a two-entry
// result buffer (output register plus skid stage) lets one more request in
// while a result waits, so the request side only stalls once both entries are
// full. Configuration registers are written through csr_we, csr_index and
// csr_wdata and should only be changed while no result is outstanding; a
// lowered limit takes effect at the next tick and a new bit count takes
// effect when the next data phase starts.
module ir_beacon_manchester_transmitter (
   input  logic                         clock,
   input  logic                         reset,
   irb_req_if.sink                      req_ch,
   irb_rsp_if.source                    rsp_ch,
   input  logic                         csr_we,
   input  logic [irb_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [irb_pkg::CsrDataW-1:0] csr_wdata
);

   irb_pkg::cfg_type    cfg;
   irb_pkg::result_type result;
   logic                buf_ready;
   logic                step;

   // A request transfer happens when valid meets ready.
   assign req_ch.ready = buf_ready;
   assign step         = req_ch.valid && buf_ready;

   irb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irb_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .tick   (req_ch.tick),
      .result (result)
   );

   irb_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (result),
      .in_ready  (buf_ready),
      .rsp       (rsp_ch)
   );

endmodule

FILE: rtl/core/irb_checker.sv
// Port-level checks for the IR beacon transmitter, bound to the top level.
// Depends on irb_pkg for the frame phase codes.
module irb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       led_level,
   input logic       mark_active,
   input logic [1:0] frame_phase,
   input logic [4:0] current_bit,
   input logic       frame_done
);

   // The pin can only be high while the carrier is gated on.
   a_led_needs_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!led_level || mark_active))
      else $error("led_level high outside a mark");

   // A finished frame always restarts with the start mark.
   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && frame_done) |-> (frame_phase == irb_pkg::FrmStartMark))
      else $error("frame_done without return to start mark");

   // Outside the data phase the bit index reads zero and only the start mark
   // gates the carrier.
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (frame_phase != irb_pkg::FrmData)) |->
         ((current_bit == 5'd0) && (mark_active == (frame_phase == irb_pkg::FrmStartMark))))
      else $error("bad fields outside data phase");

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind ir_beacon_manchester_transmitter irb_checker u_irb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .led_level   (rsp_ch.led_level),
   .mark_active (rsp_ch.mark_active),
   .frame_phase (rsp_ch.frame_phase),
   .current_bit (rsp_ch.current_bit),
   .frame_done  (rsp_ch.frame_done)
);
